/* sv/xzf_pkg.sv */
// ----------------------------------------------------------------------------
// xzf_pkg
// types, constants and crc helpers shared by the xz stored-lzma2 framer
// ----------------------------------------------------------------------------
package xzf_pkg;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_DATA   = 2'd1,
    OP_FINISH = 2'd2,
    OP_BAD    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_CHECK_MODE = 2'd0,
    CFG_DICT_PROP  = 2'd1,
    CFG_CHUNK_SIZE = 2'd2,
    CFG_STREAM_LEN = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CK_START = 2'd0,
    CK_DATA  = 2'd1,
    CK_FIN   = 2'd2,
    CK_ERR   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [7:0]  data;
    logic        hdr;
    logic        first;
    logic [15:0] lenm1;
  } cmd_t;

  typedef enum logic [3:0] {
    BS_IDLE, BS_START, BS_DHDR, BS_FEND, BS_FPAD, BS_FCHK, BS_IHDR,
    BS_VLIU, BS_VLIL, BS_IPAD, BS_ICRC, BS_FCALC, BS_FOOT
  } bst_e;

  localparam logic [1:0]  CHK_NONE  = 2'd0;
  localparam logic [1:0]  CHK_CRC32 = 2'd1;
  localparam logic [1:0]  CHK_CRC64 = 2'd2;
  localparam logic [31:0] CRC32_POLY = 32'hEDB88320;
  localparam logic [63:0] CRC64_POLY = 64'hC96C5795D7870F42;
  localparam logic [7:0]  FOOT_Y = 8'h59;
  localparam logic [7:0]  FOOT_Z = 8'h5A;
  localparam logic [6:0]  VLI_MASK = 7'h7F;

  localparam logic [1:0]  RST_CHECK_MODE = 2'd1;
  localparam logic [5:0]  RST_DICT_PROP  = 6'd8;
  localparam logic [16:0] RST_CHUNK_SIZE = 17'd65536;

  function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC32_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [63:0] crc64_step(logic [63:0] c, logic [7:0] b);
    logic [63:0] r;
    r = c ^ {56'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC64_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] magic_byte(logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'hFD;
      3'd1: r = 8'h37;
      3'd2: r = 8'h7A;
      3'd3: r = 8'h58;
      3'd4: r = 8'h5A;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] bhdr_byte(logic [1:0] i);
    logic [7:0] r;
    unique case (i)
      2'd0: r = 8'h02;
      2'd1: r = 8'h00;
      2'd2: r = 8'h21;
      default: r = 8'h01;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] flag_byte(logic [1:0] cm);
    logic [7:0] r;
    unique case (cm)
      CHK_CRC32: r = 8'h01;
      CHK_CRC64: r = 8'h04;
      default:   r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] check_len(logic [1:0] cm);
    logic [3:0] r;
    unique case (cm)
      CHK_CRC32: r = 4'd4;
      CHK_CRC64: r = 4'd8;
      default:   r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

/* sv/xzf_cmdq.sv */
// ----------------------------------------------------------------------------
// xzf_cmdq
// two-entry command queue between the front and back parts
// ----------------------------------------------------------------------------
module xzf_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xzf_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output xzf_pkg::cmd_t cmd_o
);

  xzf_pkg::cmd_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) begin
        wp_q <= ~wp_q;
      end
      if (pop_i && !empty_o) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end

endmodule

/* sv/xzf_front.sv */
// ----------------------------------------------------------------------------
// xzf_front
// accepts items, checks order and byte count, plans chunk headers
// ----------------------------------------------------------------------------
module xzf_front #(
  parameter int LENGTH_BITS = 40,
  parameter int MAX_CHUNK   = 65536
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   acc_i,
  input  logic [1:0]             opcode_i,
  input  logic [7:0]             data_byte_i,
  input  logic [16:0]            chunk_size_i,
  input  logic [LENGTH_BITS-1:0] stream_length_i,
  output xzf_pkg::cmd_t          cmd_o
);

  localparam int CW = (LENGTH_BITS > 17) ? LENGTH_BITS : 17;

  logic                   phase_q, phase_d;
  logic [LENGTH_BITS-1:0] seen_q, seen_d, remain;
  logic [16:0]            left_q, left_d, csc, len;
  logic                   first_q, first_d;
  logic [CW-1:0]          remc;

  always_comb begin
    remain = stream_length_i - seen_q;
    remc   = CW'(remain);
    if (chunk_size_i == 17'd0) begin
      csc = 17'd1;
    end else if (chunk_size_i > 17'(MAX_CHUNK)) begin
      csc = 17'(MAX_CHUNK);
    end else begin
      csc = chunk_size_i;
    end
    len = (remc < CW'(csc)) ? remc[16:0] : csc;
  end

  always_comb begin
    phase_d = phase_q;
    seen_d  = seen_q;
    left_d  = left_q;
    first_d = first_q;
    cmd_o   = '{kind: xzf_pkg::CK_ERR, data: data_byte_i, hdr: 1'b0,
                first: first_q, lenm1: 16'(len - 17'd1)};
    unique case (xzf_pkg::op_e'(opcode_i))
      xzf_pkg::OP_START: begin
        if (!phase_q) begin
          cmd_o.kind = xzf_pkg::CK_START;
          phase_d    = 1'b1;
          seen_d     = '0;
          left_d     = '0;
          first_d    = 1'b1;
        end
      end
      xzf_pkg::OP_DATA: begin
        if (phase_q && (seen_q < stream_length_i)) begin
          cmd_o.kind = xzf_pkg::CK_DATA;
          seen_d     = seen_q + 1'b1;
          if (left_q == 17'd0) begin
            cmd_o.hdr = 1'b1;
            first_d   = 1'b0;
            left_d    = len - 17'd1;
          end else begin
            left_d = left_q - 17'd1;
          end
        end
      end
      xzf_pkg::OP_FINISH: begin
        if (phase_q) begin
          phase_d = 1'b0;
          if (seen_q == stream_length_i) begin
            cmd_o.kind = xzf_pkg::CK_FIN;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      seen_q  <= '0;
      left_q  <= '0;
      first_q <= 1'b1;
    end else if (acc_i) begin
      phase_q <= phase_d;
      seen_q  <= seen_d;
      left_q  <= left_d;
      first_q <= first_d;
    end
  end

endmodule

/* sv/xzf_back.sv */
// ----------------------------------------------------------------------------
// xzf_back
// byte sequencer: headers, payload, check, index and footer, with crcs
// ----------------------------------------------------------------------------
module xzf_back #(
  parameter int LENGTH_BITS = 40
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   qempty_i,
  input  xzf_pkg::cmd_t          cmd_i,
  output logic                   qpop_o,
  input  logic [1:0]             check_mode_i,
  input  logic [5:0]             dict_prop_i,
  input  logic [LENGTH_BITS-1:0] stream_length_i,
  input  logic                   pop_i,
  output logic                   empty_o,
  output logic [7:0]             out_byte_o,
  output logic                   run_last_o,
  output logic                   stream_done_o,
  output logic                   error_o
);

  localparam int VW = LENGTH_BITS + 3;

  xzf_pkg::bst_e           st_q, st_d;
  logic [4:0]              stp_q, stp_d;
  logic [31:0]             hcrc_q, hcrc_d, hin, nh, nc32;
  logic [31:0]             crc32_q, crc32_d;
  logic [63:0]             crc64_q, crc64_d, nc64;
  logic [LENGTH_BITS:0]    cc_q, cc_d;
  logic [VW-1:0]           vli_q, vli_d;
  logic [4:0]              idx_q, idx_d;
  logic [1:0]              padn_q, padn_d;
  xzf_pkg::cmd_t           cur_q, cur_d;
  logic                    ov_q;
  logic [7:0]              ob_q;
  logic                    ol_q, od_q, oe_q;
  logic                    slot, emit, el, ed, ee, upd, hrst, pay, apply, more;
  logic [7:0]              eb, flag, back, nc32b, nc64b, nhb;

  assign slot  = !ov_q || pop_i;
  assign flag  = xzf_pkg::flag_byte(check_mode_i);
  assign back  = {5'd0, idx_q[4:2]};
  assign nh    = ~hcrc_q;
  assign nhb   = nh[{stp_q[1:0], 3'b000} +: 8];
  assign nc32  = ~crc32_q;
  assign nc32b = nc32[{stp_q[1:0], 3'b000} +: 8];
  assign nc64  = ~crc64_q;
  assign nc64b = nc64[{stp_q[2:0], 3'b000} +: 8];
  assign more  = |(vli_q >> 7);

  always_comb begin
    st_d   = st_q;
    stp_d  = stp_q;
    cc_d   = cc_q;
    vli_d  = vli_q;
    idx_d  = idx_q;
    padn_d = padn_q;
    cur_d  = cur_q;
    emit   = 1'b0;
    eb     = 8'h00;
    el     = 1'b0;
    ed     = 1'b0;
    ee     = 1'b0;
    upd    = 1'b0;
    hrst   = 1'b0;
    pay    = 1'b0;
    qpop_o = 1'b0;
    crc32_d = crc32_q;
    crc64_d = crc64_q;
    unique case (st_q)
      xzf_pkg::BS_IDLE: begin
        if (!qempty_i) begin
          unique case (cmd_i.kind)
            xzf_pkg::CK_ERR: begin
              emit = 1'b1;
              el   = 1'b1;
              ee   = 1'b1;
              qpop_o = slot;
            end
            xzf_pkg::CK_DATA: begin
              if (!cmd_i.hdr) begin
                emit   = 1'b1;
                eb     = cmd_i.data;
                el     = 1'b1;
                pay    = 1'b1;
                qpop_o = slot;
              end else begin
                qpop_o = 1'b1;
                cur_d  = cmd_i;
                st_d   = xzf_pkg::BS_DHDR;
                stp_d  = '0;
              end
            end
            xzf_pkg::CK_START: begin
              qpop_o  = 1'b1;
              st_d    = xzf_pkg::BS_START;
              stp_d   = '0;
              cc_d    = '0;
              crc32_d = '1;
              crc64_d = '1;
            end
            default: begin
              qpop_o = 1'b1;
              st_d   = xzf_pkg::BS_FEND;
            end
          endcase
        end
      end
      xzf_pkg::BS_START: begin
        emit = 1'b1;
        el   = (stp_q == 5'd23);
        hrst = (stp_q == 5'd6) || (stp_q == 5'd12);
        upd  = (stp_q == 5'd6) || (stp_q == 5'd7) || ((stp_q >= 5'd12) && (stp_q <= 5'd19));
        if (stp_q < 5'd6) begin
          eb = xzf_pkg::magic_byte(stp_q[2:0]);
        end else if (stp_q == 5'd7) begin
          eb = flag;
        end else if ((stp_q >= 5'd8) && (stp_q <= 5'd11)) begin
          eb = nhb;
        end else if ((stp_q >= 5'd12) && (stp_q <= 5'd15)) begin
          eb = xzf_pkg::bhdr_byte(stp_q[1:0]);
        end else if (stp_q == 5'd16) begin
          eb = {2'b00, dict_prop_i};
        end else if (stp_q >= 5'd20) begin
          eb = nhb;
        end
        if (slot) begin
          stp_d = stp_q + 5'd1;
          if (el) begin
            st_d = xzf_pkg::BS_IDLE;
          end
        end
      end
      xzf_pkg::BS_DHDR: begin
        emit = 1'b1;
        unique case (stp_q[1:0])
          2'd0: eb = cur_q.first ? 8'h01 : 8'h02;
          2'd1: eb = cur_q.lenm1[15:8];
          2'd2: eb = cur_q.lenm1[7:0];
          default: begin
            eb  = cur_q.data;
            el  = 1'b1;
            pay = 1'b1;
          end
        endcase
        if (slot) begin
          stp_d = stp_q + 5'd1;
          if (!pay) begin
            cc_d = cc_q + 1'b1;
          end
          if (el) begin
            st_d = xzf_pkg::BS_IDLE;
          end
        end
      end
      xzf_pkg::BS_FEND: begin
        emit = 1'b1;
        if (slot) begin
          cc_d   = cc_q + 1'b1;
          padn_d = ~cc_q[1:0];
          vli_d  = VW'(cc_q) + VW'(13) + VW'(xzf_pkg::check_len(check_mode_i));
          st_d   = xzf_pkg::BS_FPAD;
          stp_d  = '0;
        end
      end
      xzf_pkg::BS_FPAD: begin
        if (stp_q[1:0] == padn_q) begin
          st_d  = xzf_pkg::BS_FCHK;
          stp_d = '0;
        end else begin
          emit = 1'b1;
          if (slot) begin
            stp_d = stp_q + 5'd1;
          end
        end
      end
      xzf_pkg::BS_FCHK: begin
        if (stp_q == 5'(xzf_pkg::check_len(check_mode_i))) begin
          st_d  = xzf_pkg::BS_IHDR;
          stp_d = '0;
        end else begin
          emit = 1'b1;
          eb   = (check_mode_i == xzf_pkg::CHK_CRC64) ? nc64b : nc32b;
          if (slot) begin
            stp_d = stp_q + 5'd1;
          end
        end
      end
      xzf_pkg::BS_IHDR: begin
        emit = 1'b1;
        upd  = 1'b1;
        hrst = (stp_q == 5'd0);
        eb   = stp_q[0] ? 8'h01 : 8'h00;
        if (slot) begin
          idx_d = hrst ? 5'd1 : idx_q + 5'd1;
          stp_d = stp_q + 5'd1;
          if (stp_q[0]) begin
            st_d = xzf_pkg::BS_VLIU;
          end
        end
      end
      xzf_pkg::BS_VLIU, xzf_pkg::BS_VLIL: begin
        emit = 1'b1;
        upd  = 1'b1;
        eb   = {more, vli_q[6:0] & xzf_pkg::VLI_MASK};
        if (slot) begin
          idx_d = idx_q + 5'd1;
          if (more) begin
            vli_d = vli_q >> 7;
          end else if (st_q == xzf_pkg::BS_VLIU) begin
            vli_d = VW'(stream_length_i);
            st_d  = xzf_pkg::BS_VLIL;
          end else begin
            st_d = xzf_pkg::BS_IPAD;
          end
        end
      end
      xzf_pkg::BS_IPAD: begin
        if (idx_q[1:0] == 2'd0) begin
          st_d  = xzf_pkg::BS_ICRC;
          stp_d = '0;
        end else begin
          emit = 1'b1;
          upd  = 1'b1;
          if (slot) begin
            idx_d = idx_q + 5'd1;
          end
        end
      end
      xzf_pkg::BS_ICRC: begin
        emit = 1'b1;
        eb   = nhb;
        if (slot) begin
          stp_d = stp_q + 5'd1;
          if (stp_q[1:0] == 2'd3) begin
            st_d  = xzf_pkg::BS_FCALC;
            stp_d = '0;
          end
        end
      end
      xzf_pkg::BS_FCALC: begin
        upd  = 1'b1;
        hrst = (stp_q == 5'd0);
        eb   = (stp_q == 5'd0) ? back : ((stp_q == 5'd5) ? flag : 8'h00);
        stp_d = stp_q + 5'd1;
        if (stp_q == 5'd5) begin
          st_d  = xzf_pkg::BS_FOOT;
          stp_d = '0;
        end
      end
      xzf_pkg::BS_FOOT: begin
        emit = 1'b1;
        if (stp_q < 5'd4) begin
          eb = nhb;
        end else if (stp_q == 5'd4) begin
          eb = back;
        end else if (stp_q == 5'd9) begin
          eb = flag;
        end else if (stp_q == 5'd10) begin
          eb = xzf_pkg::FOOT_Y;
        end else if (stp_q == 5'd11) begin
          eb = xzf_pkg::FOOT_Z;
          el = 1'b1;
          ed = 1'b1;
        end
        if (slot) begin
          stp_d = stp_q + 5'd1;
          if (el) begin
            st_d = xzf_pkg::BS_IDLE;
          end
        end
      end
      default: begin
        st_d = xzf_pkg::BS_IDLE;
      end
    endcase
    apply = emit ? slot : 1'b1;
    hin   = hrst ? 32'hFFFFFFFF : hcrc_q;
    hcrc_d = (upd && apply) ? xzf_pkg::crc32_step(hin, eb) : hcrc_q;
    if (pay && slot) begin
      cc_d    = cc_q + 1'b1;
      crc32_d = xzf_pkg::crc32_step(crc32_q, eb);
      crc64_d = xzf_pkg::crc64_step(crc64_q, eb);
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    vli_q  <= vli_d;
    idx_q  <= idx_d;
    padn_q <= padn_d;
    hcrc_q <= hcrc_d;
    if (emit && slot) begin
      ob_q <= eb;
      ol_q <= el;
      od_q <= ed;
      oe_q <= ee;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= xzf_pkg::BS_IDLE;
      stp_q   <= '0;
      cc_q    <= '0;
      crc32_q <= '1;
      crc64_q <= '1;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      stp_q   <= stp_d;
      cc_q    <= cc_d;
      crc32_q <= crc32_d;
      crc64_q <= crc64_d;
      if (emit && slot) begin
        ov_q <= 1'b1;
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign empty_o       = !ov_q;
  assign out_byte_o    = ob_q;
  assign run_last_o    = ol_q;
  assign stream_done_o = od_q;
  assign error_o       = oe_q;

endmodule

/* sv/xz_stored_lzma2_framer_unit.sv */
// ----------------------------------------------------------------------------
// xz_stored_lzma2_framer_unit
// wraps a byte stream in a single-block xz container of stored lzma2 chunks
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  input    | push_i / full_o   | opcode_i, data_byte_i
//  result   | empty_o / pop_i   | out_byte_o, run_last_o, stream_done_o, error_o
//  config   | cfg_we_i          | cfg_idx_i, cfg_wdata_i
//
//  payload bytes inside a chunk pass at one per cycle unless the result register is full
//  a chunk header adds control and length bytes; start emits the stream and block headers
//  the back sequencer stalls on a full result register, and some of its steps emit no byte
//  a two-entry command queue lets input continue while the back part is busy
//  reset is asynchronous; index, padding, vli, header crc and data registers are not reset
// ----------------------------------------------------------------------------
module xz_stored_lzma2_framer_unit #(
  parameter int LENGTH_BITS = 40,
  parameter int MAX_CHUNK   = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        stream_done_o,
  output logic        error_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [39:0] cfg_wdata_i
);

  localparam int SLW = (LENGTH_BITS < 40) ? LENGTH_BITS : 40;

  logic [1:0]             cm_q;
  logic [5:0]             dp_q;
  logic [16:0]            cs_q;
  logic [LENGTH_BITS-1:0] sl_q;
  xzf_pkg::cmd_t          fcmd, qcmd;
  logic                   acc, qempty, qpop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cm_q <= xzf_pkg::RST_CHECK_MODE;
      dp_q <= xzf_pkg::RST_DICT_PROP;
      cs_q <= xzf_pkg::RST_CHUNK_SIZE;
      sl_q <= '0;
    end else if (cfg_we_i) begin
      unique case (xzf_pkg::cfg_idx_e'(cfg_idx_i))
        xzf_pkg::CFG_CHECK_MODE: cm_q <= cfg_wdata_i[1:0];
        xzf_pkg::CFG_DICT_PROP:  dp_q <= cfg_wdata_i[5:0];
        xzf_pkg::CFG_CHUNK_SIZE: cs_q <= cfg_wdata_i[16:0];
        default:                 sl_q <= LENGTH_BITS'(cfg_wdata_i[SLW-1:0]);
      endcase
    end
  end

  assign acc = push_i && !full_o;

  xzf_front #(
    .LENGTH_BITS(LENGTH_BITS),
    .MAX_CHUNK  (MAX_CHUNK)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .acc_i          (acc),
    .opcode_i       (opcode_i),
    .data_byte_i    (data_byte_i),
    .chunk_size_i   (cs_q),
    .stream_length_i(sl_q),
    .cmd_o          (fcmd)
  );

  xzf_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .cmd_i  (fcmd),
    .full_o (full_o),
    .pop_i  (qpop),
    .empty_o(qempty),
    .cmd_o  (qcmd)
  );

  xzf_back #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .qempty_i       (qempty),
    .cmd_i          (qcmd),
    .qpop_o         (qpop),
    .check_mode_i   (cm_q),
    .dict_prop_i    (dp_q),
    .stream_length_i(sl_q),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .out_byte_o     (out_byte_o),
    .run_last_o     (run_last_o),
    .stream_done_o  (stream_done_o),
    .error_o        (error_o)
  );

endmodule
